// ===== rtl/stfd_pkg.sv =====
`timescale 1ns / 1ps

package stfd_pkg;

	localparam int ADDR_W    = 20;
	localparam int PIX_W     = 17;
	localparam int JOB_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam int DRAW_ZERO_POS = 6;
	localparam int FORCE_TOP_POS = 15;

	localparam logic [2:0] MODE_4BPP_BANK = 3'd0;
	localparam logic [2:0] MODE_4BPP_LUT  = 3'd1;
	localparam logic [2:0] MODE_8BPP_64   = 3'd2;
	localparam logic [2:0] MODE_8BPP_128  = 3'd3;
	localparam logic [2:0] MODE_8BPP_256  = 3'd4;

	localparam logic CMD_WRITE = 1'b0;

	localparam logic [15:0] NIB_BANK_MASK = 16'hFFF0;
	localparam logic [7:0]  DOT_MASK_64   = 8'h3F;
	localparam logic [15:0] BANK_MASK_64  = 16'hFFC0;
	localparam logic [7:0]  DOT_MASK_128  = 8'h7F;
	localparam logic [15:0] BANK_MASK_128 = 16'hFF80;
	localparam logic [7:0]  DOT_MASK_256  = 8'hFF;
	localparam logic [15:0] BANK_MASK_256 = 16'hFF00;

	typedef struct packed {
		logic        command;
		logic [18:0] mem_address;
		logic [15:0] mem_word;
		logic [18:0] texture_base;
		logic [15:0] bank_word;
		logic [2:0]  colour_mode;
		logic [15:0] draw_mode;
		logic [8:0]  texel_x;
		logic [7:0]  texel_y;
		logic [8:0]  texture_width;
	} item_t;

	typedef struct packed {
		logic [15:0] pixel_colour;
		logic [10:0] palette_index;
		logic        from_palette;
		logic        force_top_bit;
		logic        is_transparent;
	} result_t;

	typedef enum logic [2:0] {
		J_WRITE,
		J_NIB_BANK,
		J_NIB_LUT,
		J_BYTE,
		J_WORD
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
		logic [2:0]        mode;
		logic              nib_lo;
		logic              draw_zero;
		logic              top;
	} job_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EVAL1,
		B_EVAL2
	} back_state_t;

endpackage

// ===== rtl/sprite_texel_fetch_decode.sv =====
`timescale 1ns / 1ps
// the back sequencer does a write in B_IDLE, reads a fetch there, decodes it in B_EVAL1;
// a lookup-mode fetch whose texel is drawn also reads the colour word, ending in B_EVAL2
// throughput: one write per cycle while the result queue has room; a fetch holds the
// back sequencer, which owns both byte banks and works one item at a time, until its
// result is pushed. Reset clears control state and starts a clearing pass, one row of
// both banks per cycle; full stays high until the pass is done

module sprite_texel_fetch_decode
	import stfd_pkg::*;
#(
	parameter int MEM_BYTES = 524288
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic    front_full;
	logic    job_push;
	logic    job_full;
	job_t    job_in;
	job_t    job_out;
	logic    job_empty;
	logic    job_pop;
	logic    res_push;
	logic    res_full;
	result_t res_d;
	logic    clearing;

	assign full = front_full || clearing;

	stfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && !clearing),
		.full     (front_full),
		.item     (item),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_in)
	);

	stfd_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	stfd_back #(
		.MEM_BYTES (MEM_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_d),
		.clearing  (clearing)
	);

	stfd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_d),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

// ===== rtl/stfd_fifo.sv =====
`timescale 1ns / 1ps

module stfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/stfd_front.sv =====
`timescale 1ns / 1ps

module stfd_front
	import stfd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  job_push,
	input  logic  job_full,
	output job_t  job
);

	logic             v_s1;
	item_t            item_s1;
	logic             v_s2;
	job_t             job_s2;
	logic [PIX_W-1:0] pix_s2;

	logic             s1_ready;
	logic             s2_ready;
	logic [PIX_W-1:0] pix;
	job_t             job_d;

	assign s2_ready = !v_s2 || !job_full;
	assign s1_ready = !v_s1 || s2_ready;
	assign full     = !s1_ready;
	assign job_push = v_s2 && !job_full;

	// texel index: y * width + x
	assign pix = PIX_W'(item_s1.texel_y) * PIX_W'(item_s1.texture_width)
		+ PIX_W'(item_s1.texel_x);

	always_comb begin
		job_d           = '0;
		job_d.mode      = item_s1.colour_mode;
		job_d.nib_lo    = pix[0];
		job_d.draw_zero = item_s1.draw_mode[DRAW_ZERO_POS];
		job_d.top       = item_s1.draw_mode[FORCE_TOP_POS];
		if (item_s1.command == CMD_WRITE) begin
			job_d.kind = J_WRITE;
			job_d.addr = ADDR_W'(item_s1.mem_address);
			job_d.data = item_s1.mem_word;
		end else begin
			job_d.addr = ADDR_W'(item_s1.texture_base);
			job_d.data = item_s1.bank_word;
			unique case (item_s1.colour_mode)
				MODE_4BPP_BANK: job_d.kind = J_NIB_BANK;
				MODE_4BPP_LUT:  job_d.kind = J_NIB_LUT;
				MODE_8BPP_64,
				MODE_8BPP_128,
				MODE_8BPP_256:  job_d.kind = J_BYTE;
				default:        job_d.kind = J_WORD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= push;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && s1_ready) begin
			item_s1 <= item;
		end
		if (v_s1 && s2_ready) begin
			job_s2 <= job_d;
			pix_s2 <= pix;
		end
	end

	// byte address of the texel: half, one or two bytes per texel
	always_comb begin
		job = job_s2;
		unique case (job_s2.kind)
			J_WRITE:               job.addr = job_s2.addr;
			J_NIB_BANK, J_NIB_LUT: job.addr = job_s2.addr + ADDR_W'(pix_s2[PIX_W-1:1]);
			J_BYTE:                job.addr = job_s2.addr + ADDR_W'(pix_s2);
			default:               job.addr = job_s2.addr + {2'b00, pix_s2, 1'b0};
		endcase
	end

endmodule

// ===== rtl/stfd_back.sv =====
`timescale 1ns / 1ps

module stfd_back
	import stfd_pkg::*;
#(
	parameter int MEM_BYTES = 524288
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_empty,
	input  job_t    job,
	output logic    job_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res,
	output logic    clearing
);

	localparam int AW   = $clog2(MEM_BYTES);
	localparam int RW   = AW - 1;
	localparam int ROWS = MEM_BYTES / 2;

	// even bank holds even byte addresses, odd bank odd ones
	logic [7:0] bank_even [ROWS];
	logic [7:0] bank_odd  [ROWS];

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [RW-1:0] clr_row_q;
	logic        rd_odd_q;
	logic [7:0]  rd_even_data_q;
	logic [7:0]  rd_odd_data_q;

	logic              start;
	logic              write_go;
	logic [ADDR_W-1:0] rd_addr;
	logic [AW-1:0]     rd_a;
	logic [RW-1:0]     rd_row;
	logic [RW-1:0]     rd_even_row;
	logic [AW-1:0]     wr_a;
	logic [RW-1:0]     wr_row;
	logic [RW-1:0]     wr_even_row;
	logic              mem_we;
	logic [RW-1:0]     even_wrow;
	logic [RW-1:0]     odd_wrow;
	logic [7:0]        even_wdata;
	logic [7:0]        odd_wdata;

	logic [7:0]        hi_byte;
	logic [7:0]        lo_byte;
	logic [15:0]       word;
	logic [3:0]        nib;
	logic [7:0]        dmask;
	logic [15:0]       bmask;
	logic [7:0]        dot;
	logic [15:0]       pal_full;
	logic              nib_transp;
	logic [ADDR_W-1:0] lut_addr;

	assign start    = !job_empty && !res_full;
	assign clearing = (state_q == B_CLEAR);

	// address split; a word's low byte sits in the other bank, one row on when odd
	assign rd_a        = rd_addr[AW-1:0];
	assign rd_row      = rd_a[AW-1:1];
	assign rd_even_row = rd_a[0] ? rd_row + RW'(1) : rd_row;
	assign wr_a        = job.addr[AW-1:0];
	assign wr_row      = wr_a[AW-1:1];
	assign wr_even_row = wr_a[0] ? wr_row + RW'(1) : wr_row;

	assign mem_we     = clearing || write_go;
	assign even_wrow  = clearing ? clr_row_q : wr_even_row;
	assign odd_wrow   = clearing ? clr_row_q : wr_row;
	assign even_wdata = clearing ? 8'h00 : (wr_a[0] ? job.data[7:0] : job.data[15:8]);
	assign odd_wdata  = clearing ? 8'h00 : (wr_a[0] ? job.data[15:8] : job.data[7:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bank_even[even_wrow] <= even_wdata;
			bank_odd[odd_wrow]   <= odd_wdata;
		end
		rd_even_data_q <= bank_even[rd_even_row];
		rd_odd_data_q  <= bank_odd[rd_row];
		rd_odd_q       <= rd_a[0];
		if (job_pop) begin
			job_q <= job;
		end
	end

	assign hi_byte = rd_odd_q ? rd_odd_data_q : rd_even_data_q;
	assign lo_byte = rd_odd_q ? rd_even_data_q : rd_odd_data_q;
	assign word    = {hi_byte, lo_byte};

	assign nib        = job_q.nib_lo ? hi_byte[3:0] : hi_byte[7:4];
	assign nib_transp = (nib == 4'h0) && !job_q.draw_zero;
	assign lut_addr   = {1'b0, job_q.data, 3'b000} + {15'b0, nib, 1'b0};

	always_comb begin
		priority if (job_q.mode == MODE_8BPP_64) begin
			dmask = DOT_MASK_64;
			bmask = BANK_MASK_64;
		end else if (job_q.mode == MODE_8BPP_128) begin
			dmask = DOT_MASK_128;
			bmask = BANK_MASK_128;
		end else begin
			dmask = DOT_MASK_256;
			bmask = BANK_MASK_256;
		end
	end

	assign dot      = hi_byte & dmask;
	assign pal_full = (job_q.data & bmask) | {8'h00, dot};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_row_q == RW'(ROWS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (start && job.kind != J_WRITE) begin
					state_d = B_EVAL1;
				end
			end
			B_EVAL1: begin
				if (job_q.kind == J_NIB_LUT && !nib_transp) begin
					state_d = B_EVAL2;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_EVAL2: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		write_go = 1'b0;
		rd_addr  = job.addr;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			B_CLEAR: begin
			end
			B_IDLE: begin
				if (start) begin
					job_pop = 1'b1;
					if (job.kind == J_WRITE) begin
						write_go = 1'b1;
						res_push = 1'b1;
					end
				end
			end
			B_EVAL1: begin
				rd_addr = lut_addr;
				unique case (job_q.kind)
					J_NIB_BANK: begin
						res_push = 1'b1;
						if (nib_transp) begin
							res.is_transparent = 1'b1;
						end else begin
							res.palette_index = 11'((job_q.data & NIB_BANK_MASK) | {12'h000, nib});
							res.from_palette  = 1'b1;
							res.force_top_bit = job_q.top;
						end
					end
					J_NIB_LUT: begin
						// colour word comes from the table on the next read
						if (nib_transp) begin
							res_push           = 1'b1;
							res.is_transparent = 1'b1;
						end
					end
					J_BYTE: begin
						res_push = 1'b1;
						if (dot == 8'h00 && !job_q.draw_zero) begin
							res.is_transparent = 1'b1;
						end else begin
							res.palette_index = pal_full[10:0];
							res.from_palette  = 1'b1;
							res.force_top_bit = job_q.top;
						end
					end
					default: begin
						res_push = 1'b1;
						if (word == 16'h0000 && !job_q.draw_zero) begin
							res.is_transparent = 1'b1;
						end else begin
							res.pixel_colour = word | {job_q.top, 15'h0000};
						end
					end
				endcase
			end
			B_EVAL2: begin
				res_push         = 1'b1;
				res.pixel_colour = word | {job_q.top, 15'h0000};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_row_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_row_q <= clr_row_q + RW'(1);
			end
		end
	end

endmodule

// ===== rtl/stfd_checker.sv =====
`timescale 1ns / 1ps

module stfd_checker
	import stfd_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    push,
	input logic    full,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	// items taken in whose results are not yet popped
	logic [3:0] outstanding_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_beat && !out_beat) begin
			outstanding_q <= outstanding_q + 4'd1;
		end else if (out_beat && !in_beat) begin
			outstanding_q <= outstanding_q - 4'd1;
		end
	end

	a_full_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full)
		else $error("full low right after reset");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outstanding_q != 4'd0)
		else $error("result shown with no item outstanding");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.is_transparent || result.force_top_bit) |->
		(result.is_transparent ? (result.from_palette == 1'b0 && result.pixel_colour == 16'h0000
			&& result.palette_index == 11'h000 && result.force_top_bit == 1'b0)
		: result.from_palette == 1'b1))
		else $error("inconsistent result fields");

endmodule

bind sprite_texel_fetch_decode stfd_checker u_stfd_checker (.*);
